// ===== design/psar_pkg.sv =====
// ----------------------------------------------------------------------------
// psar_pkg
// Shared types, constants and address update functions for the scroll and
// address register block.
// ----------------------------------------------------------------------------
`default_nettype none

package psar_pkg;

    localparam int ADDR_W    = 15;
    localparam int DATA_W    = 8;
    localparam int FINE_W    = 3;
    localparam int COARSE_W  = 5;
    localparam int COMMAND_W = 4;

    localparam logic [COARSE_W-1:0] COARSE_MAX       = 5'd31;
    localparam logic [COARSE_W-1:0] ROW_LAST_VISIBLE = 5'd29;
    localparam logic [FINE_W-1:0]   FINE_MAX         = 3'd7;
    localparam logic [ADDR_W-1:0]   ROW_STEP         = 15'd32;
    localparam logic [ADDR_W-1:0]   COLUMN_STEP      = 15'd1;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_CTRL_WRITE   = 4'd0,
        CMD_SCROLL_WRITE = 4'd1,
        CMD_ADDR_WRITE   = 4'd2,
        CMD_STATUS_READ  = 4'd3,
        CMD_DATA_ACCESS  = 4'd4,
        CMD_HINC         = 4'd5,
        CMD_VINC         = 4'd6,
        CMD_COPY_HORIZ   = 4'd7,
        CMD_COPY_ALL     = 4'd8,
        CMD_UNLOCK       = 4'd9
    } command_t;

    // Coarse X steps by one; at the right edge it wraps and swaps the
    // horizontal nametable.
    function automatic addr_t bump_horizontal(input addr_t a);
        addr_t r;
        r = a;
        if (a[4:0] == COARSE_MAX) begin
            r[4:0] = '0;
            r[10]  = ~a[10];
        end
        else begin
            r[4:0] = a[4:0] + 5'd1;
        end
        return r;
    endfunction

    // Fine Y counts to seven, then coarse Y advances. Row 29 wraps with a
    // vertical nametable swap; row 31 wraps without one.
    function automatic addr_t bump_vertical(input addr_t a);
        addr_t r;
        r = a;
        if (a[14:12] != FINE_MAX) begin
            r[14:12] = a[14:12] + 3'd1;
        end
        else begin
            r[14:12] = '0;
            if (a[9:5] == ROW_LAST_VISIBLE) begin
                r[9:5] = '0;
                r[11]  = ~a[11];
            end
            else if (a[9:5] == COARSE_MAX) begin
                r[9:5] = '0;
            end
            else begin
                r[9:5] = a[9:5] + 5'd1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/ppu_scroll_address_registers_core.sv =====
// ----------------------------------------------------------------------------
// ppu_scroll_address_registers_core
// Scroll and address register unit: current and temporary VRAM addresses,
// fine X, write toggle, control bits and the post-reset write lockout.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the item channel (item_valid / item_ready) with their
// write byte, the vertical blank flag and the rendering flag. Each item
// produces exactly one result on the result channel (result_valid /
// result_ready) carrying v, t, fine X, the toggle and the NMI request.
// An accepted item is captured in the input register; the state update
// and the result are then computed by one pass of combinational logic
// and loaded into the result register, once that register is free or
// being emptied, so the result passes the input and result registers in
// turn. One item is accepted every cycle as long as the result register
// is empty or is being emptied in the same cycle.
// When the receiver stalls, the result register holds its item, the input
// register fills behind it and item_ready then drops until a result leaves.
// Reset clears both addresses, fine X, the toggle and the control bits, and
// sets the write lockout, so control, scroll and address writes are ignored
// until an unlock command has been processed.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_scroll_address_registers_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [psar_pkg::COMMAND_W-1:0] command,
    input  wire logic [psar_pkg::DATA_W-1:0]    write_data,
    input  wire logic                           vblank_flag,
    input  wire logic                           rendering_active,

    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic [psar_pkg::ADDR_W-1:0]         vram_address,
    output logic [psar_pkg::ADDR_W-1:0]         temp_address,
    output logic [psar_pkg::FINE_W-1:0]         fine_x,
    output logic                                toggle_state,
    output logic                                nmi_request
);

    import psar_pkg::*;

    // Input register stage.
    logic              in_valid_reg;
    command_t          in_command_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_vblank_reg;
    logic              in_rendering_reg;

    // Architectural state.
    addr_t             current_addr_reg,   current_addr_next;
    addr_t             temporary_addr_reg, temporary_addr_next;
    logic [FINE_W-1:0] fine_scroll_x_reg,  fine_scroll_x_next;
    logic              second_write_reg,   second_write_next;
    logic              step_by_row_reg,    step_by_row_next;
    logic              nmi_enabled_reg,    nmi_enabled_next;
    logic              write_lockout_reg,  write_lockout_next;
    logic              nmi_next;

    // Result register stage.
    logic              out_valid_reg;
    logic              out_nmi_reg;

    logic              advance;

    // The input item moves into the result register when that register is
    // free or being emptied; the state commits at the same edge.
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready) begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid) begin
            in_command_reg   <= command_t'(command);
            in_data_reg      <= write_data;
            in_vblank_reg    <= vblank_flag;
            in_rendering_reg <= rendering_active;
        end
    end

    // One command applied to the current state.
    always_comb
    begin
        current_addr_next   = current_addr_reg;
        temporary_addr_next = temporary_addr_reg;
        fine_scroll_x_next  = fine_scroll_x_reg;
        second_write_next   = second_write_reg;
        step_by_row_next    = step_by_row_reg;
        nmi_enabled_next    = nmi_enabled_reg;
        write_lockout_next  = write_lockout_reg;
        nmi_next            = 1'b0;

        unique case (in_command_reg)
            CMD_CTRL_WRITE:
            begin
                if (!write_lockout_reg) begin
                    nmi_next = in_vblank_reg && !nmi_enabled_reg && in_data_reg[7];
                    nmi_enabled_next            = in_data_reg[7];
                    step_by_row_next            = in_data_reg[2];
                    temporary_addr_next[11:10]  = in_data_reg[1:0];
                end
            end
            CMD_SCROLL_WRITE:
            begin
                if (!write_lockout_reg) begin
                    if (!second_write_reg) begin
                        temporary_addr_next[4:0] = in_data_reg[7:3];
                        fine_scroll_x_next       = in_data_reg[2:0];
                    end
                    else begin
                        temporary_addr_next[9:5]   = in_data_reg[7:3];
                        temporary_addr_next[14:12] = in_data_reg[2:0];
                    end
                    second_write_next = ~second_write_reg;
                end
            end
            CMD_ADDR_WRITE:
            begin
                if (!write_lockout_reg) begin
                    if (!second_write_reg) begin
                        temporary_addr_next[13:8] = in_data_reg[5:0];
                        temporary_addr_next[14]   = 1'b0;
                    end
                    else begin
                        temporary_addr_next[7:0] = in_data_reg;
                        current_addr_next = {temporary_addr_reg[14:8], in_data_reg};
                    end
                    second_write_next = ~second_write_reg;
                end
            end
            CMD_STATUS_READ:
            begin
                second_write_next = 1'b0;
            end
            CMD_DATA_ACCESS:
            begin
                if (in_rendering_reg) begin
                    current_addr_next = bump_vertical(bump_horizontal(current_addr_reg));
                end
                else begin
                    current_addr_next = current_addr_reg
                                      + (step_by_row_reg ? ROW_STEP : COLUMN_STEP);
                end
            end
            CMD_HINC:
            begin
                current_addr_next = bump_horizontal(current_addr_reg);
            end
            CMD_VINC:
            begin
                current_addr_next = bump_vertical(current_addr_reg);
            end
            CMD_COPY_HORIZ:
            begin
                current_addr_next[4:0] = temporary_addr_reg[4:0];
                current_addr_next[10]  = temporary_addr_reg[10];
            end
            CMD_COPY_ALL:
            begin
                current_addr_next = temporary_addr_reg;
            end
            CMD_UNLOCK:
            begin
                write_lockout_next = 1'b0;
            end
            default:
            begin
                // Unused codes leave the state as it is.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            current_addr_reg   <= '0;
            temporary_addr_reg <= '0;
            fine_scroll_x_reg  <= '0;
            second_write_reg   <= 1'b0;
            step_by_row_reg    <= 1'b0;
            nmi_enabled_reg    <= 1'b0;
            write_lockout_reg  <= 1'b1;
        end
        else if (advance) begin
            current_addr_reg   <= current_addr_next;
            temporary_addr_reg <= temporary_addr_next;
            fine_scroll_x_reg  <= fine_scroll_x_next;
            second_write_reg   <= second_write_next;
            step_by_row_reg    <= step_by_row_next;
            nmi_enabled_reg    <= nmi_enabled_next;
            write_lockout_reg  <= write_lockout_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_nmi_reg <= nmi_next;
        end
    end

    // The state registers hold exactly the values reported with the most
    // recent result, so they drive the result fields directly.
    assign result_valid = out_valid_reg;
    assign vram_address = current_addr_reg;
    assign temp_address = temporary_addr_reg;
    assign fine_x       = fine_scroll_x_reg;
    assign toggle_state = second_write_reg;
    assign nmi_request  = out_nmi_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scroll and address register unit. A scoreboard
// class keeps its own copy of v, t, fine X, the toggle, the control bits and
// the write lockout, predicts one result per accepted item and compares every
// returned result field by field. Stimulus is a directed opening followed by
// random register set-up sequences, render-time event runs and noise, with
// bursty sending and a patterned result stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psar_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_CAP   = 100;

    // Worst case per item is an idle gap before a burst plus a receiver stall
    // per result; the limit allows several times that.
    localparam int CYCLE_LIMIT  = 400000;

    // Codes above the last defined command must leave everything unchanged.
    localparam logic [COMMAND_W-1:0] CMD_UNUSED_FIRST = COMMAND_W'(int'(CMD_UNLOCK) + 1);
    localparam logic [COMMAND_W-1:0] CMD_UNUSED_LAST  = '1;

    // One result as the block reports it.
    typedef struct {
        addr_t               vram;
        addr_t               temp;
        logic [FINE_W-1:0]   fine;
        logic                toggle;
        logic                nmi;
    } scroll_view_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow register state and the queue of expected results.
    // ------------------------------------------------------------------------
    class scroll_regs_tracker;
        addr_t             cur_addr;
        addr_t             tmp_addr;
        logic [FINE_W-1:0] fine_scroll;
        logic              second_write;
        logic              row_step;
        logic              nmi_on;
        logic              locked;
        int                errors;
        int                checked;
        scroll_view_t      expected_views[$];

        function new();
            cur_addr     = '0;
            tmp_addr     = '0;
            fine_scroll  = '0;
            second_write = 1'b0;
            row_step     = 1'b0;
            nmi_on       = 1'b0;
            locked       = 1'b1;
            errors       = 0;
            checked      = 0;
        endfunction

        // Coarse X plus one; the carry out of the five-bit field flips the
        // horizontal nametable bit.
        function addr_t next_column(addr_t a);
            addr_t r;
            logic  carry;
            r = a;
            {carry, r[4:0]} = {1'b0, a[4:0]} + 6'd1;
            if (carry)
                r[10] = ~r[10];
            return r;
        endfunction

        // Fine Y plus one; on its carry coarse Y moves on, wrapping at the
        // last visible row with a vertical nametable flip, and at the top of
        // the field without one.
        function addr_t next_row(addr_t a);
            addr_t r;
            logic  carry;
            r = a;
            {carry, r[14:12]} = {1'b0, a[14:12]} + 4'd1;
            if (carry)
            begin
                case (a[9:5])
                    ROW_LAST_VISIBLE:
                    begin
                        r[9:5] = '0;
                        r[11]  = ~r[11];
                    end
                    COARSE_MAX: r[9:5] = '0;
                    default:    r[9:5] = a[9:5] + 5'd1;
                endcase
            end
            return r;
        endfunction

        // Applies one accepted command to the shadow state and queues the
        // result that the block should return for it.
        function void accept_command(logic [COMMAND_W-1:0] c, logic [DATA_W-1:0] d,
                                     logic vb, logic ra);
            scroll_view_t view;
            logic         nmi_now;
            nmi_now = 1'b0;
            case (c)
                CMD_CTRL_WRITE:
                    if (!locked)
                    begin
                        nmi_now         = vb && !nmi_on && d[7];
                        nmi_on          = d[7];
                        row_step        = d[2];
                        tmp_addr[11:10] = d[1:0];
                    end
                CMD_SCROLL_WRITE:
                    if (!locked)
                    begin
                        if (!second_write)
                        begin
                            tmp_addr[4:0] = d[7:3];
                            fine_scroll   = d[2:0];
                        end
                        else
                        begin
                            tmp_addr[9:5]   = d[7:3];
                            tmp_addr[14:12] = d[2:0];
                        end
                        second_write = ~second_write;
                    end
                CMD_ADDR_WRITE:
                    if (!locked)
                    begin
                        if (!second_write)
                        begin
                            tmp_addr[13:8] = d[5:0];
                            tmp_addr[14]   = 1'b0;
                        end
                        else
                        begin
                            tmp_addr[7:0] = d;
                            cur_addr      = tmp_addr;
                        end
                        second_write = ~second_write;
                    end
                CMD_STATUS_READ: second_write = 1'b0;
                CMD_DATA_ACCESS:
                    if (ra)
                        cur_addr = next_row(next_column(cur_addr));
                    else
                        cur_addr = cur_addr + (row_step ? ROW_STEP : COLUMN_STEP);
                CMD_HINC:        cur_addr = next_column(cur_addr);
                CMD_VINC:        cur_addr = next_row(cur_addr);
                CMD_COPY_HORIZ:
                begin
                    cur_addr[4:0] = tmp_addr[4:0];
                    cur_addr[10]  = tmp_addr[10];
                end
                CMD_COPY_ALL:    cur_addr = tmp_addr;
                CMD_UNLOCK:      locked = 1'b0;
                default:         ;
            endcase
            view.vram   = cur_addr;
            view.temp   = tmp_addr;
            view.fine   = fine_scroll;
            view.toggle = second_write;
            view.nmi    = nmi_now;
            expected_views.push_back(view);
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        task report(string what);
            errors++;
            // The count keeps running past the cap so the verdict stays right.
            if (errors <= REPORT_CAP)
                $display("tb: mismatch at result %0d: %s", checked, what);
        endtask

        task check_result(scroll_view_t got);
            scroll_view_t want;
            if (expected_views.size() == 0)
            begin
                report("result with no item outstanding");
                checked++;
                return;
            end
            want = expected_views.pop_front();
            if (got.vram !== want.vram)
                report($sformatf("vram_address %h, expected %h", got.vram, want.vram));
            if (got.temp !== want.temp)
                report($sformatf("temp_address %h, expected %h", got.temp, want.temp));
            if (got.fine !== want.fine)
                report($sformatf("fine_x %h, expected %h", got.fine, want.fine));
            if (got.toggle !== want.toggle)
                report($sformatf("toggle_state %b, expected %b", got.toggle, want.toggle));
            if (got.nmi !== want.nmi)
                report($sformatf("nmi_request %b, expected %b", got.nmi, want.nmi));
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n            = 1'b0;
    logic                  item_valid       = 1'b0;
    logic [COMMAND_W-1:0]  command          = '0;
    logic [DATA_W-1:0]     write_data       = '0;
    logic                  vblank_flag      = 1'b0;
    logic                  rendering_active = 1'b0;
    logic                  result_ready     = 1'b0;
    logic                  item_ready;
    logic                  result_valid;
    addr_t                 vram_address;
    addr_t                 temp_address;
    logic [FINE_W-1:0]     fine_x;
    logic                  toggle_state;
    logic                  nmi_request;

    scroll_regs_tracker    tracker;
    int                    items_sent  = 0;
    int                    burst_left  = 0;
    int                    cycle_count = 0;
    int                    stall_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    ppu_scroll_address_registers_core dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .command          (command),
        .write_data       (write_data),
        .vblank_flag      (vblank_flag),
        .rendering_active (rendering_active),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .vram_address     (vram_address),
        .temp_address     (temp_address),
        .fine_x           (fine_x),
        .toggle_state     (toggle_state),
        .nmi_request      (nmi_request)
    );

    // Random field values at the width of their ports.
    function automatic logic [DATA_W-1:0] rand_byte();
        return DATA_W'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_flag();
        return 1'($urandom_range(0, 1));
    endfunction

    // ------------------------------------------------------------------------
    // Sending side. Items go out in bursts of random length; between bursts
    // the valid line drops for a random number of cycles, sometimes none, so
    // long back-to-back stretches occur as well. The task is always entered
    // just after a rising edge, and the payload is held until the handshake.
    // ------------------------------------------------------------------------
    task send_item(input logic [COMMAND_W-1:0] c, input logic [DATA_W-1:0] d,
                   input logic vb, input logic ra);
        int idle;
        if (burst_left == 0)
        begin
            idle = $urandom_range(0, 7);
            if (idle != 0)
            begin
                item_valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        item_valid       <= 1'b1;
        command          <= c;
        write_data       <= d;
        vblank_flag      <= vb;
        rendering_active <= ra;
        // Ready is sampled as it stood just before the edge.
        do
            @(posedge clk);
        while (!item_ready);
        tracker.accept_command(c, d, vb, ra);
        items_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Receiving side. Every result taken is checked against the oldest
    // expectation. Ready follows a pattern of its own that moves through four
    // modes: always ready, mostly ready, coin-toss and long stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_side
        scroll_view_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got.vram   = vram_address;
            got.temp   = temp_address;
            got.fine   = fine_x;
            got.toggle = toggle_state;
            got.nmi    = nmi_request;
            tracker.check_result(got);
        end
        stall_count++;
        case ((stall_count / 97) % 4)
            0:       result_ready <= 1'b1;
            1:       result_ready <= ($urandom_range(0, 3) != 0);
            2:       result_ready <= rand_flag();
            default: result_ready <= (stall_count % 8 == 0);
        endcase
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int pick;
        int n;
        int directed_count;
        tracker = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Writes straight after reset fall on the lockout and must be
        // ignored entirely, NMI included; a data access still moves v.
        send_item(CMD_CTRL_WRITE,   8'hFF, 1'b1, 1'b0);
        send_item(CMD_SCROLL_WRITE, 8'hFF, 1'b1, 1'b1);
        send_item(CMD_ADDR_WRITE,   8'hFF, 1'b0, 1'b0);
        send_item(CMD_DATA_ACCESS,  8'h00, 1'b0, 1'b0);
        send_item(CMD_UNLOCK,       8'h00, 1'b0, 1'b0);

        // Unused codes at both ends of their range change nothing.
        send_item(CMD_UNUSED_LAST,  8'hFF, 1'b1, 1'b1);
        send_item(CMD_UNUSED_FIRST, 8'h00, 1'b0, 1'b0);

        // NMI fires only when the enable goes from off to on in vertical
        // blank; a second enabling write, or one outside blank, is silent.
        send_item(CMD_CTRL_WRITE,   8'h84, 1'b1, 1'b0);
        send_item(CMD_CTRL_WRITE,   8'h80, 1'b1, 1'b0);
        send_item(CMD_CTRL_WRITE,   8'h03, 1'b1, 1'b0);
        send_item(CMD_CTRL_WRITE,   8'h80, 1'b0, 1'b0);

        // Scroll to the right-most column and the last visible row, copy it
        // to v, then step across both wrap points.
        send_item(CMD_SCROLL_WRITE, 8'hFF, 1'b0, 1'b0);
        send_item(CMD_SCROLL_WRITE, 8'hEF, 1'b0, 1'b0);
        send_item(CMD_COPY_ALL,     8'h00, 1'b0, 1'b0);
        send_item(CMD_HINC,         8'h00, 1'b0, 1'b0);
        send_item(CMD_VINC,         8'h00, 1'b0, 1'b0);
        send_item(CMD_DATA_ACCESS,  8'h00, 1'b0, 1'b1);

        // The first address write clears bit 14; the second loads v.
        send_item(CMD_ADDR_WRITE,   8'hFF, 1'b0, 1'b0);
        send_item(CMD_ADDR_WRITE,   8'h00, 1'b0, 1'b0);

        // A status read between the two halves resets the toggle.
        send_item(CMD_SCROLL_WRITE, 8'h00, 1'b0, 1'b0);
        send_item(CMD_STATUS_READ,  8'h00, 1'b0, 1'b0);

        // Fill t completely, step by 32 past the top of the address space,
        // wrap coarse Y from row 31 without a flip, copy the horizontal part.
        send_item(CMD_SCROLL_WRITE, 8'h07, 1'b0, 1'b0);
        send_item(CMD_SCROLL_WRITE, 8'hFF, 1'b0, 1'b0);
        send_item(CMD_CTRL_WRITE,   8'h07, 1'b0, 1'b0);
        send_item(CMD_COPY_ALL,     8'h00, 1'b0, 1'b0);
        send_item(CMD_DATA_ACCESS,  8'h00, 1'b0, 1'b0);
        send_item(CMD_COPY_ALL,     8'h00, 1'b0, 1'b0);
        send_item(CMD_VINC,         8'h00, 1'b0, 1'b0);
        send_item(CMD_COPY_HORIZ,   8'h00, 1'b0, 1'b0);
        directed_count = items_sent;

        // Random part: mostly well-formed register set-up and render-time
        // sequences with random content, the rest loose items of any code.
        while (items_sent < directed_count + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // Scroll set-up, usually after a status read.
                if ($urandom_range(0, 3) != 0)
                    send_item(CMD_STATUS_READ, rand_byte(), rand_flag(), rand_flag());
                send_item(CMD_SCROLL_WRITE, rand_byte(), rand_flag(), rand_flag());
                send_item(CMD_SCROLL_WRITE, rand_byte(), rand_flag(), rand_flag());
            end
            else if (pick < 45)
            begin
                // Address set-up followed by a run of data accesses.
                if ($urandom_range(0, 3) != 0)
                    send_item(CMD_STATUS_READ, rand_byte(), rand_flag(), rand_flag());
                send_item(CMD_ADDR_WRITE, rand_byte(), rand_flag(), rand_flag());
                send_item(CMD_ADDR_WRITE, rand_byte(), rand_flag(), rand_flag());
                n = $urandom_range(0, 6);
                repeat (n)
                    send_item(CMD_DATA_ACCESS, rand_byte(), rand_flag(), rand_flag());
            end
            else if (pick < 70)
            begin
                // A stretch of scanline events: tile steps across the line,
                // a few row steps, then the horizontal reload.
                if ($urandom_range(0, 3) == 0)
                    send_item(CMD_COPY_ALL, rand_byte(), rand_flag(), rand_flag());
                n = $urandom_range(0, 33);
                repeat (n)
                    send_item(CMD_HINC, rand_byte(), rand_flag(), rand_flag());
                n = $urandom_range(1, 9);
                repeat (n)
                    send_item(CMD_VINC, rand_byte(), rand_flag(), rand_flag());
                send_item(CMD_COPY_HORIZ, rand_byte(), rand_flag(), rand_flag());
            end
            else if (pick < 80)
            begin
                send_item(CMD_CTRL_WRITE, rand_byte(), rand_flag(), rand_flag());
            end
            else
            begin
                // Noise: any code, unused ones included, with any fields.
                send_item(COMMAND_W'($urandom_range(0, int'(CMD_UNUSED_LAST))),
                          rand_byte(), rand_flag(), rand_flag());
            end
        end
        item_valid <= 1'b0;

        // Drain the outstanding results, then give any stray result time to
        // show itself before the verdict.
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/psar_pkg.sv
design/ppu_scroll_address_registers_core.sv
tb/tb.sv
